FILE: src/rfw_pkg.sv
// rfw_pkg: shared types and constants for the rf wattmeter averaging core
// depends on nothing; used by every module in src
`timescale 1ns / 1ps
`default_nettype none
package rfw_pkg;

  localparam int PEAK_W  = 17;
  localparam int MW_W    = 18;
  localparam int DWT_W   = 11;
  localparam int CODE_W  = 10;
  localparam int CODES_W = 14;
  localparam int SCALED_W = 26;
  localparam int DIV_W   = 34;
  localparam int DVS_W   = 17;
  localparam int LEN_W   = 6;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMP   = 1'd1;

  localparam logic [CFG_W-1:0] OFFSET_RESET = 16'd17;
  localparam logic [DVS_W-1:0] ADC_FULL     = 17'd1023;
  localparam logic [DVS_W-1:0] MW_SCALE     = 17'd100000;
  localparam logic [DVS_W-1:0] DW_SCALE     = 17'd100;
  localparam logic [DVS_W-1:0] DW_HALF      = 17'd50;

  typedef struct packed {
    logic [CODE_W-1:0] divider_code;
    logic [CODE_W-1:0] diode_code;
    logic              supply_low;
  } rfw_in_t;

  typedef struct packed {
    logic [PEAK_W-1:0] sample_peak_mv;
    logic [PEAK_W-1:0] avg_peak_mv;
    logic [MW_W-1:0]   power_mw;
    logic [DWT_W-1:0]  power_dw;
  } rfw_out_t;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } rfw_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } rfw_div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEAK,
    S_RING,
    S_AVG,
    S_SQR,
    S_MW,
    S_DW,
    S_OUT
  } rfw_state_t;

endpackage
`default_nettype wire

FILE: src/rfw_serial_div.sv
// rfw_serial_div: restoring divider, one quotient bit per cycle
// depends on rfw_pkg; dividend is left aligned, len bits are processed
`timescale 1ns / 1ps
`default_nettype none
module rfw_serial_div (
  input  wire                   clk,
  input  wire                   rst,
  input  rfw_pkg::rfw_div_req_t req,
  output rfw_pkg::rfw_div_rsp_t rsp
);
  import rfw_pkg::*;

  logic             busy;
  logic             done;
  logic [LEN_W-1:0] cnt;
  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem, dvd[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.len;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == LEN_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dvs <= req.divisor;
      quo <= '0;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_W-2:0], 1'b0};
      quo <= {quo[DIV_W-2:0], fits};
      rem <= fits ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
`default_nettype wire

FILE: src/rfw_serial_sqr.sv
// rfw_serial_sqr: shift and add squarer, one multiplier bit per cycle
// depends on rfw_pkg
`timescale 1ns / 1ps
`default_nettype none
module rfw_serial_sqr (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [rfw_pkg::PEAK_W-1:0]    value,
  output logic                         done,
  output logic [2*rfw_pkg::PEAK_W-1:0] product
);
  import rfw_pkg::*;

  localparam int CNT_W = $clog2(PEAK_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [2*PEAK_W-1:0]   mcand;
  logic [PEAK_W-1:0]     mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PEAK_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand   <= {{PEAK_W{1'b0}}, value};
      mplier  <= value;
      product <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        product <= product + mcand;
      end
      mcand  <= {mcand[2*PEAK_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[PEAK_W-1:1]};
    end
  end

endmodule
`default_nettype wire

FILE: src/rf_wattmeter_averaging_core.sv
// rf_wattmeter_averaging_core: top level, sequencer, sample ring and config
// depends on rfw_pkg, rfw_serial_div and rfw_serial_sqr
//
// input channel in_valid/in_stall/in_data carries one transaction per converter
// sample pair; output channel out_valid/out_stall/out_data returns one
// transaction per input with the peak, the moving average and the power.
// config: cfg_we writes cfg_data into register cfg_index (0 offset, 1 comp);
// the user writes only while the block is idle; the block does not enforce it.
// one item is handled at a time through a bit serial divider and squarer:
// peak divide, average divide over the sum width (21 bits at the default
// window of 10), square, mw divide and dw divide, with control states
// around them; out_valid rises when the output state loads the result.
// in_stall is high from acceptance until the result is loaded into the
// output register; the next input is taken while that result still waits.
// a stalled output holds its transaction and the block waits before loading
// the next one.
// reset empties the ring (no clearing pass: a fill count marks unwritten
// entries as zero), sets offset 17 and compensation on.
`timescale 1ns / 1ps
`default_nettype none
module rf_wattmeter_averaging_core #(
  parameter int WINDOW_LEN = 10
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  rfw_pkg::rfw_in_t                in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output rfw_pkg::rfw_out_t               out_data,
  input  wire                             cfg_we,
  input  wire [rfw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [rfw_pkg::CFG_W-1:0]        cfg_data
);
  import rfw_pkg::*;

  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = PEAK_W + $clog2(WINDOW_LEN);

  rfw_state_t         state;
  rfw_state_t         state_next;
  logic [CFG_W-1:0]   offset;
  logic               comp_en;
  logic [PEAK_W-1:0]  peak;
  logic [PEAK_W-1:0]  avg;
  logic [MW_W-1:0]    mw;
  logic [DWT_W-1:0]   dw;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   cnt_next;
  logic [SLOT_W-1:0]  slot;
  logic [PEAK_W-1:0]  ring_mem [WINDOW_LEN];
  logic [PEAK_W-1:0]  rd_q;
  logic [PEAK_W-1:0]  old_val;
  logic               full;
  logic               in_take;
  logic               out_free;

  logic [CODES_W-1:0]  codes;
  logic [SCALED_W-1:0] scaled;
  logic [PEAK_W-1:0]   avg_next;
  logic [DWT_W-1:0]    dw_next;

  rfw_div_req_t          div_req;
  rfw_div_rsp_t          div_rsp;
  logic                  sqr_start;
  logic                  sqr_done;
  logic [2*PEAK_W-1:0]   sqr_prod;

  rfw_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rfw_serial_sqr u_sqr (
    .clk     (clk),
    .rst     (rst),
    .start   (sqr_start),
    .value   (avg_next),
    .done    (sqr_done),
    .product (sqr_prod)
  );

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign full     = (cnt == CNT_W'(WINDOW_LEN));
  assign old_val  = full ? rd_q : '0;
  assign sum_next = sum + SUM_W'(peak) - SUM_W'(old_val);
  assign cnt_next = full ? cnt : cnt + 1'b1;

  // 11 * divider code plus the diode code when compensation is on
  assign codes  = CODES_W'({in_data.divider_code, 3'b000})
                + CODES_W'({in_data.divider_code, 1'b0})
                + CODES_W'(in_data.divider_code)
                + (comp_en ? CODES_W'(in_data.diode_code) : '0);
  assign scaled = in_data.supply_low ? {2'b00, codes, 10'd0} : {codes, 12'd0};

  assign avg_next = div_rsp.quotient[PEAK_W-1:0]
                  + PEAK_W'({div_rsp.remainder, 1'b0} >= (DVS_W + 1)'(cnt));
  assign dw_next  = div_rsp.quotient[DWT_W-1:0]
                  + DWT_W'(div_rsp.remainder >= DW_HALF);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_take) state_next = S_PEAK;
      S_PEAK: if (div_rsp.done) state_next = S_RING;
      S_RING: state_next = S_AVG;
      S_AVG:  if (div_rsp.done) state_next = S_SQR;
      S_SQR:  if (sqr_done) state_next = S_MW;
      S_MW:   if (div_rsp.done) state_next = S_DW;
      S_DW:   if (div_rsp.done) state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    div_req   = '0;
    sqr_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        div_req.start    = in_take;
        div_req.len      = LEN_W'(SCALED_W);
        div_req.dividend = {scaled, {(DIV_W-SCALED_W){1'b0}}};
        div_req.divisor  = ADC_FULL;
      end
      S_RING: begin
        div_req.start    = 1'b1;
        div_req.len      = LEN_W'(SUM_W);
        div_req.dividend = {sum_next, {(DIV_W-SUM_W){1'b0}}};
        div_req.divisor  = DVS_W'(cnt_next);
      end
      S_AVG: begin
        sqr_start = div_rsp.done;
      end
      S_SQR: begin
        div_req.start    = sqr_done;
        div_req.len      = LEN_W'(DIV_W);
        div_req.dividend = sqr_prod;
        div_req.divisor  = MW_SCALE;
      end
      S_MW: begin
        div_req.start    = div_rsp.done;
        div_req.len      = LEN_W'(MW_W);
        div_req.dividend = {div_rsp.quotient[MW_W-1:0], {(DIV_W-MW_W){1'b0}}};
        div_req.divisor  = DW_SCALE;
      end
      default: begin
        div_req   = '0;
        sqr_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      offset    <= OFFSET_RESET;
      comp_en   <= 1'b1;
      sum       <= '0;
      cnt       <= '0;
      slot      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OFFSET: offset  <= cfg_data;
          REG_COMP:   comp_en <= cfg_data[0];
          default:    offset  <= offset;
        endcase
      end
      if (state == S_RING) begin
        sum  <= sum_next;
        cnt  <= cnt_next;
        slot <= (slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot + 1'b1;
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ring storage
  always_ff @(posedge clk) begin
    rd_q <= ring_mem[slot];
    if (state == S_RING) begin
      ring_mem[slot] <= peak;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_PEAK && div_rsp.done) begin
      peak <= PEAK_W'(div_rsp.quotient[PEAK_W-1:0] + PEAK_W'(offset));
    end
    if (state == S_AVG && div_rsp.done) begin
      avg <= avg_next;
    end
    if (state == S_MW && div_rsp.done) begin
      mw <= div_rsp.quotient[MW_W-1:0];
    end
    if (state == S_DW && div_rsp.done) begin
      dw <= dw_next;
    end
    if (state == S_OUT && out_free) begin
      out_data.sample_peak_mv <= peak;
      out_data.avg_peak_mv    <= avg;
      out_data.power_mw       <= mw;
      out_data.power_dw       <= dw;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(WINDOW_LEN))
    else $error("fill count above window length");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(WINDOW_LEN - 1))
    else $error("ring slot out of range");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("output transaction loaded outside output state");

  a_ring_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_RING && !full) |=> cnt == $past(cnt) + 1'b1)
    else $error("fill count did not advance while filling");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_rf_wattmeter_averaging_core.sv
// tb_rf_wattmeter_averaging_core: self-checking testbench for the rf wattmeter core
// depends on rfw_pkg and rf_wattmeter_averaging_core; predicts each reading in the
// bench and checks every output transaction field by field under random stalls
`timescale 1ns / 1ps
module tb_rf_wattmeter_averaging_core;
  import rfw_pkg::*;

  localparam int WIN = 10;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS = 223;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  rfw_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rfw_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_OFFSET;
  logic [CFG_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  rf_wattmeter_averaging_core #(.WINDOW_LEN(WIN)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // bench copy of the meter state
  logic [15:0] offset_mv;
  logic comp_on;
  logic [PEAK_W-1:0] peak_ring [WIN];
  int unsigned slot, unfilled;
  int unsigned peak_sum;

  rfw_out_t reading_q[$];
  rfw_out_t typed_q[$];   // typed expectations for directed rows, used in place of predictor
  int errors = 0;
  int n_in = 0, n_out = 0, idle_cycles = 0;
  bit quiet = 0;
  int hold_cycles = 0;

  function automatic rfw_out_t next_reading(rfw_in_t s);
    rfw_out_t r;
    int unsigned vref, codes, pk, cnt, avg;
    longint unsigned mw, dw;
    vref = s.supply_low ? 1024 : 4096;
    codes = s.divider_code * 11 + (comp_on ? s.diode_code : 0);
    pk = codes * vref / 1023 + offset_mv;
    peak_sum = peak_sum + pk - peak_ring[slot];
    peak_ring[slot] = pk[PEAK_W-1:0];
    slot = (slot + 1 >= WIN) ? 0 : slot + 1;
    if (unfilled > 0) unfilled--;
    cnt = WIN - unfilled;
    avg = peak_sum / cnt;
    if (2 * (peak_sum % cnt) >= cnt) avg++;
    mw = longint'(avg) * avg / 100000;
    dw = mw / 100;
    if (mw % 100 >= 50) dw++;
    r.sample_peak_mv = pk[PEAK_W-1:0];
    r.avg_peak_mv = avg[PEAK_W-1:0];
    r.power_mw = mw[MW_W-1:0];
    r.power_dw = dw[DWT_W-1:0];
    return r;
  endfunction

  initial begin
    offset_mv = 16'd17;
    comp_on = 1'b1;
    for (int i = 0; i < WIN; i++) peak_ring[i] = '0;
    slot = 0;
    unfilled = WIN;
    peak_sum = 0;
  end

  // monitor: config, input and output transactions sampled at the edge
  always @(posedge clk) begin
    rfw_out_t r, e;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == REG_OFFSET) offset_mv = cfg_data;
        else if (cfg_index == REG_COMP) comp_on = cfg_data[0];
      end
      if (in_valid && !in_stall) begin
        r = next_reading(in_data);
        if (typed_q.size() > 0) r = typed_q.pop_front();
        reading_q.push_back(r);
        n_in++;
      end
      if (out_valid && !out_stall) begin
        n_out++;
        if (reading_q.size() == 0) begin
          $display("%0t: unexpected output transaction %p", $time, out_data);
          errors++;
        end else begin
          e = reading_q.pop_front();
          if (out_data.sample_peak_mv !== e.sample_peak_mv) begin
            $display("%0t: sample_peak_mv expected %0d actual %0d", $time,
                     e.sample_peak_mv, out_data.sample_peak_mv);
            errors++;
          end
          if (out_data.avg_peak_mv !== e.avg_peak_mv) begin
            $display("%0t: avg_peak_mv expected %0d actual %0d", $time,
                     e.avg_peak_mv, out_data.avg_peak_mv);
            errors++;
          end
          if (out_data.power_mw !== e.power_mw) begin
            $display("%0t: power_mw expected %0d actual %0d", $time,
                     e.power_mw, out_data.power_mw);
            errors++;
          end
          if (out_data.power_dw !== e.power_dw) begin
            $display("%0t: power_dw expected %0d actual %0d", $time,
                     e.power_dw, out_data.power_dw);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d transactions outstanding", $time,
                 reading_q.size());
        $display("tb_rf_wattmeter_averaging_core: FAIL");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (reading_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send(rfw_in_t s);
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic rfw_in_t rand_sample();
    rfw_in_t s;
    s.divider_code = $urandom_range(0, 1023);
    s.diode_code = $urandom_range(0, 1023);
    s.supply_low = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0: s.divider_code = 10'd1023;
      1: s.divider_code = 10'd0;
      2: s.diode_code = 10'd1023;
      3: s.diode_code = 10'd0;
      default: ;
    endcase
    return s;
  endfunction

  typedef struct {
    logic [9:0] dv;
    logic [9:0] dd;
    logic lo;
    bit typed;
    rfw_out_t r;
  } stim_row_t;

  stim_row_t dir_tbl[] = '{
    '{10'd0, 10'd0, 1'b0, 1, '{17'd17, 17'd17, 18'd0, 11'd0}},
    '{10'd0, 10'd0, 1'b1, 1, '{17'd17, 17'd17, 18'd0, 11'd0}},
    '{10'd1023, 10'd1023, 1'b0, 0, '0},
    '{10'd1023, 10'd1023, 1'b1, 0, '0},
    '{10'd1023, 10'd0, 1'b0, 0, '0},
    '{10'd0, 10'd1023, 1'b0, 0, '0},
    '{10'd512, 10'd1, 1'b1, 0, '0},
    '{10'd1, 10'd512, 1'b0, 0, '0},
    '{10'd1023, 10'd1023, 1'b0, 0, '0},
    '{10'd1023, 10'd1023, 1'b0, 0, '0},
    '{10'd1023, 10'd1023, 1'b0, 0, '0},
    '{10'd1023, 10'd1023, 1'b0, 0, '0},
    '{10'd341, 10'd682, 1'b1, 0, '0},
    '{10'd682, 10'd341, 1'b0, 0, '0}
  };

  initial begin
    rfw_in_t s;
    logic [15:0] offs [6] = '{16'd65535, 16'd0, 16'd17, 16'd0, 16'd65535, 16'd0};
    logic [15:0] comps [6] = '{16'hfffe, 16'h0001, 16'h8000, 16'hffff, 16'h0001, 16'h0000};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows: filling window, extremes, wrap of the ring
    foreach (dir_tbl[i]) begin
      s.divider_code = dir_tbl[i].dv;
      s.diode_code = dir_tbl[i].dd;
      s.supply_low = dir_tbl[i].lo;
      if (dir_tbl[i].typed) typed_q.push_back(dir_tbl[i].r);
      send(s);
    end
    drain();
    write_reg(REG_OFFSET, 16'hffff);
    write_reg(REG_COMP, 16'h0000);
    s = '{10'd1023, 10'd1023, 1'b0};
    send(s);
    s = '{10'd1023, 10'd1023, 1'b1};
    send(s);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        write_reg(REG_OFFSET, $urandom_range(0, 65535));
        write_reg(REG_COMP, $urandom_range(0, 65535));
      end else begin
        write_reg(REG_OFFSET, offs[p]);
        write_reg(REG_COMP, comps[p]);
      end
      if (p == 5) quiet = 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 20) hold_cycles = 600;
        send(rand_sample());
      end
      drain();
    end

    drain();
    $display("covered %0d input and %0d output transactions, offset and compensation",
             n_in, n_out);
    $display("extremes, ring fill and wrap, long output hold-off and idle bursts");
    if (errors == 0 && reading_q.size() == 0) begin
      $display("tb_rf_wattmeter_averaging_core: PASS");
    end else begin
      $display("tb_rf_wattmeter_averaging_core: FAIL");
    end
    $finish;
  end
endmodule

FILE: filelist.f
src/rfw_pkg.sv
src/rfw_serial_div.sv
src/rfw_serial_sqr.sv
src/rf_wattmeter_averaging_core.sv
tb/tb_rf_wattmeter_averaging_core.sv
